// ===== hdl/pfa_pkg.sv =====
// Shared types, constants and saturation helper for the particle advection step.
package pfa_pkg;

  localparam int unsigned IDX_W     = 12;
  localparam int unsigned VAL_W     = 24;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned PCOUNT    = 4096;
  localparam int unsigned GRID_W_LG = 6;
  localparam int unsigned GRID_H_LG = 6;
  localparam int unsigned CELLS     = 4096;
  localparam int unsigned STAGES    = 10;

  localparam logic [1:0] REQ_FIELD = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_STEP  = 2'd2;

  localparam logic [1:0] REG_GAIN  = 2'd0;
  localparam logic [1:0] REG_RATE  = 2'd1;
  localparam logic [1:0] REG_SCX   = 2'd2;
  localparam logic [1:0] REG_SCY   = 2'd3;

  typedef struct packed {
    logic [15:0] gain;
    logic [15:0] rate;
    logic [15:0] scale_x;
    logic [15:0] scale_y;
  } cfg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] org_x;
    logic signed [VAL_W-1:0] org_y;
    logic signed [VAL_W-1:0] pos_x;
    logic signed [VAL_W-1:0] pos_y;
    logic signed [VAL_W-1:0] vel_x;
    logic signed [VAL_W-1:0] vel_y;
    logic                    act;
    logic [TIME_W-1:0]       atime;
  } part_t;

  function automatic logic signed [VAL_W-1:0] sat24(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sd8388607;
    lo = -34'sd8388608;
    if (v > hi) begin
      sat24 = 24'sh7FFFFF;
    end else if (v < lo) begin
      sat24 = 24'sh800000;
    end else begin
      sat24 = v[VAL_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/pfa_cfg_regs.sv =====
// APB-style register file holding gain, damping rate and cell scales.
module pfa_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output pfa_pkg::cfg_t      cfg
);

  pfa_pkg::cfg_t cfg_r;
  logic          wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain    <= 16'd256;
      cfg_r.rate    <= 16'd11796;
      cfg_r.scale_x <= 16'd4096;
      cfg_r.scale_y <= 16'd4096;
    end else if (wr_en) begin
      case (paddr[3:2])
        pfa_pkg::REG_GAIN: cfg_r.gain    <= pwdata[15:0];
        pfa_pkg::REG_RATE: cfg_r.rate    <= pwdata[15:0];
        pfa_pkg::REG_SCX:  cfg_r.scale_x <= pwdata[15:0];
        pfa_pkg::REG_SCY:  cfg_r.scale_y <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pfa_pkg::REG_GAIN: prdata = {16'd0, cfg_r.gain};
      pfa_pkg::REG_RATE: prdata = {16'd0, cfg_r.rate};
      pfa_pkg::REG_SCX:  prdata = {16'd0, cfg_r.scale_x};
      pfa_pkg::REG_SCY:  prdata = {16'd0, cfg_r.scale_y};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/particle_field_advection_step_top.sv =====
// Top level: ten-stage particle advection pipeline with particle and field memories.
// A step request gives its result on out_strobe after it passes the pipeline stages and the output register.
// Throughput: one request per cycle; busy rises only while an earlier request to the
// same particle is in flight, or for a field write while a step is before its field read.
// Reset clears the pipeline valid bits and loads the register defaults; memories are
// not cleared and hold nothing defined until written.
module particle_field_advection_step_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_req_type,
  input  logic [11:0]         in_target_index,
  input  logic signed [23:0]  in_value_x,
  input  logic signed [23:0]  in_value_y,
  input  logic [15:0]         in_time_step,
  input  logic [31:0]         in_now_time,
  input  logic                in_skip_field,
  output logic                out_strobe,
  output logic [11:0]         out_particle_id,
  output logic signed [23:0]  out_new_pos_x,
  output logic signed [23:0]  out_new_pos_y,
  output logic                out_is_active,
  output logic [31:0]         out_active_since,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  pfa_pkg::cfg_t cfg;

  pfa_cfg_regs u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  pfa_pkg::part_t      pmem [pfa_pkg::PCOUNT];
  logic signed [23:0]  fmem_x [pfa_pkg::CELLS];
  logic signed [23:0]  fmem_y [pfa_pkg::CELLS];

  logic [pfa_pkg::STAGES-1:1] v_r;
  logic [pfa_pkg::STAGES-1:1] load_r;
  logic [11:0]         idx_r  [1:pfa_pkg::STAGES-1];
  logic                skip_r [1:pfa_pkg::STAGES-1];
  logic [15:0]         dt_r   [1:pfa_pkg::STAGES-1];
  logic signed [23:0]  lvx_r  [1:pfa_pkg::STAGES-1];
  logic signed [23:0]  lvy_r  [1:pfa_pkg::STAGES-1];
  logic [31:0]         now_r  [1:pfa_pkg::STAGES-1];
  pfa_pkg::part_t      p_r    [1:pfa_pkg::STAGES-1];
  pfa_pkg::part_t      p_nxt  [2:pfa_pkg::STAGES-1];

  logic signed [40:0]  mvx_r, mvy_r;
  logic [31:0]         damp_r [2:pfa_pkg::STAGES-1];
  logic signed [40:0]  sx_r, sy_r;
  logic                ingrid_r;
  logic [11:0]         cell_r;
  logic signed [23:0]  fx_r, fy_r;
  logic signed [40:0]  gfx_r, gfy_r;
  logic                ingrid6_r, ingrid7_r, ingrid8_r;
  logic signed [57:0]  gdx_r, gdy_r;
  logic signed [56:0]  vdx_r, vdy_r;

  logic                out_strobe_r;
  logic [11:0]         out_id_r;
  logic signed [23:0]  out_px_r, out_py_r;
  logic                out_act_r;
  logic [31:0]         out_since_r;

  logic                accept;
  logic                is_step, is_load, is_field;
  logic                idx_hit, step_early;
  logic signed [40:0]  sx_mag, sy_mag;
  logic [16:0]         qx, qy;
  logic                gx_ok, gy_ok;
  logic signed [23:0]  vel8_x, vel8_y;
  logic signed [23:0]  vfx_nxt, vfy_nxt;
  pfa_pkg::part_t      wb_nxt;

  assign is_field = (in_req_type == pfa_pkg::REQ_FIELD);
  assign is_load  = (in_req_type == pfa_pkg::REQ_LOAD);
  assign is_step  = (in_req_type == pfa_pkg::REQ_STEP);

  always_comb begin
    idx_hit    = 1'b0;
    step_early = 1'b0;
    for (int s = 1; s < pfa_pkg::STAGES; s++) begin
      if (v_r[s] && idx_r[s] == in_target_index) begin
        idx_hit = 1'b1;
      end
      if (s <= 5 && v_r[s] && !load_r[s]) begin
        step_early = 1'b1;
      end
    end
  end

  assign busy   = ((is_load || is_step) && idx_hit) || (is_field && step_early);
  assign accept = start && !busy;

  always_comb begin
    sx_mag = sx_r[40] ? -sx_r : sx_r;
    sy_mag = sy_r[40] ? -sy_r : sy_r;
    qx     = sx_mag[40:24];
    qy     = sy_mag[40:24];
    gx_ok  = (qx < 17'd64) && (!sx_r[40] || qx == 17'd0);
    gy_ok  = (qy < 17'd64) && (!sy_r[40] || qy == 17'd0);
  end

  always_comb begin
    vel8_x = ingrid8_r ? pfa_pkg::sat24(34'(p_r[8].vel_x) + 34'(gdx_r >>> 24))
                       : p_r[8].vel_x;
    vel8_y = ingrid8_r ? pfa_pkg::sat24(34'(p_r[8].vel_y) + 34'(gdy_r >>> 24))
                       : p_r[8].vel_y;
  end

  always_comb begin
    for (int s = 2; s < pfa_pkg::STAGES; s++) begin
      p_nxt[s] = p_r[s-1];
    end
    if (!p_r[1].act && p_r[1].pos_x != p_r[1].org_x && p_r[1].pos_y != p_r[1].org_y) begin
      p_nxt[2].act   = 1'b1;
      p_nxt[2].atime = now_r[1];
    end
    p_nxt[3].pos_x = pfa_pkg::sat24(34'(p_r[2].pos_x) + 34'(mvx_r >>> 16));
    p_nxt[3].pos_y = pfa_pkg::sat24(34'(p_r[2].pos_y) + 34'(mvy_r >>> 16));
    p_nxt[9].vel_x = vel8_x;
    p_nxt[9].vel_y = vel8_y;
  end

  always_comb begin
    vfx_nxt = pfa_pkg::sat24(34'(p_r[9].vel_x) - 34'(vdx_r >>> 32));
    vfy_nxt = pfa_pkg::sat24(34'(p_r[9].vel_y) - 34'(vdy_r >>> 32));
    wb_nxt  = p_r[9];
    if (load_r[9]) begin
      wb_nxt.org_x = lvx_r[9];
      wb_nxt.org_y = lvy_r[9];
      wb_nxt.pos_x = lvx_r[9];
      wb_nxt.pos_y = lvy_r[9];
      wb_nxt.vel_x = '0;
      wb_nxt.vel_y = '0;
      wb_nxt.act   = 1'b0;
      wb_nxt.atime = '0;
    end else begin
      wb_nxt.vel_x = vfx_nxt;
      wb_nxt.vel_y = vfy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r          <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      v_r[1] <= accept && (is_load || is_step);
      for (int s = 2; s < pfa_pkg::STAGES; s++) begin
        v_r[s] <= v_r[s-1];
      end
      out_strobe_r <= v_r[9] && !load_r[9];
    end
  end

  always_ff @(posedge clk) begin
    load_r[1] <= is_load;
    idx_r[1]  <= in_target_index;
    skip_r[1] <= in_skip_field;
    dt_r[1]   <= in_time_step;
    lvx_r[1]  <= in_value_x;
    lvy_r[1]  <= in_value_y;
    now_r[1]  <= in_now_time;
    p_r[1]    <= pmem[in_target_index];
    for (int s = 2; s < pfa_pkg::STAGES; s++) begin
      load_r[s] <= load_r[s-1];
      idx_r[s]  <= idx_r[s-1];
      skip_r[s] <= skip_r[s-1];
      dt_r[s]   <= dt_r[s-1];
      lvx_r[s]  <= lvx_r[s-1];
      lvy_r[s]  <= lvy_r[s-1];
      now_r[s]  <= now_r[s-1];
      p_r[s]    <= p_nxt[s];
    end
    damp_r[2] <= cfg.rate * dt_r[1];
    for (int s = 3; s < pfa_pkg::STAGES; s++) begin
      damp_r[s] <= damp_r[s-1];
    end

    mvx_r <= p_r[1].vel_x * $signed({1'b0, dt_r[1]});
    mvy_r <= p_r[1].vel_y * $signed({1'b0, dt_r[1]});

    sx_r <= p_r[3].pos_x * $signed({1'b0, cfg.scale_x});
    sy_r <= p_r[3].pos_y * $signed({1'b0, cfg.scale_y});

    ingrid_r <= gx_ok && gy_ok;
    cell_r   <= {qy[5:0], qx[5:0]};

    fx_r      <= fmem_x[cell_r];
    fy_r      <= fmem_y[cell_r];
    ingrid6_r <= ingrid_r && !skip_r[5];

    gfx_r     <= $signed({1'b0, cfg.gain}) * fx_r;
    gfy_r     <= $signed({1'b0, cfg.gain}) * fy_r;
    ingrid7_r <= ingrid6_r;

    gdx_r     <= gfx_r * $signed({1'b0, dt_r[7]});
    gdy_r     <= gfy_r * $signed({1'b0, dt_r[7]});
    ingrid8_r <= ingrid7_r;

    vdx_r <= vel8_x * $signed({1'b0, damp_r[8]});
    vdy_r <= vel8_y * $signed({1'b0, damp_r[8]});

    out_id_r    <= idx_r[9];
    out_px_r    <= p_r[9].pos_x;
    out_py_r    <= p_r[9].pos_y;
    out_act_r   <= p_r[9].act;
    out_since_r <= p_r[9].act ? p_r[9].atime : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (v_r[9]) begin
      pmem[idx_r[9]] <= wb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_field) begin
      fmem_x[in_target_index] <= in_value_x;
      fmem_y[in_target_index] <= in_value_y;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_particle_id  = out_id_r;
  assign out_new_pos_x    = out_px_r;
  assign out_new_pos_y    = out_py_r;
  assign out_is_active    = out_act_r;
  assign out_active_since = out_since_r;

endmodule

// ===== tb/particle_field_advection_step_top_tb.sv =====
// Self-checking testbench for the particle field advection step block.
module particle_field_advection_step_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int GRID_DIM = 64;

  typedef struct {
    logic [11:0]        id;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic               act;
    logic [31:0]        since;
  } step_result_t;

  class advection_scoreboard;
    longint org_x[pfa_pkg::PCOUNT], org_y[pfa_pkg::PCOUNT];
    longint pos_x[pfa_pkg::PCOUNT], pos_y[pfa_pkg::PCOUNT];
    longint vel_x[pfa_pkg::PCOUNT], vel_y[pfa_pkg::PCOUNT];
    bit     act[pfa_pkg::PCOUNT];
    logic [31:0] atime[pfa_pkg::PCOUNT];
    longint force_x[pfa_pkg::CELLS], force_y[pfa_pkg::CELLS];
    bit     written[pfa_pkg::CELLS];
    longint gain = 256, rate = 11796, scale_x = 4096, scale_y = 4096;
    step_result_t pending_steps[$];
    int errors = 0;
    int steps_checked = 0;
    int active_seen = 0;

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function longint clamp24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    function longint trunc_down(longint v, int s);
      if (v >= 0) return v >>> s;
      return -((-v) >>> s);
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        pfa_pkg::REG_GAIN: gain = val;
        pfa_pkg::REG_RATE: rate = val;
        pfa_pkg::REG_SCX:  scale_x = val;
        default:           scale_y = val;
      endcase
    endfunction

    // True when a step of this particle would read only a field entry that holds data.
    function bit field_ready(logic [11:0] idx, logic [15:0] dt);
      longint dl, nx, ny, cx, cy;
      dl = dt;
      nx = clamp24(pos_x[idx] + ((vel_x[idx] * dl) >>> 16));
      ny = clamp24(pos_y[idx] + ((vel_y[idx] * dl) >>> 16));
      cx = trunc_down(nx * scale_x, 24);
      cy = trunc_down(ny * scale_y, 24);
      if (cx >= 0 && cx < GRID_DIM && cy >= 0 && cy < GRID_DIM)
        return written[cy * GRID_DIM + cx];
      return 1;
    endfunction

    function void accept_request(logic [1:0] kind, logic [11:0] idx,
                                 logic signed [23:0] vx, logic signed [23:0] vy,
                                 logic [15:0] dt, logic [31:0] now, logic skip);
      longint dl, nx, ny, vlx, vly, cx, cy, grid_pos, damp;
      step_result_t r;
      dl = dt;
      if (kind == pfa_pkg::REQ_FIELD) begin
        force_x[idx] = vx;
        force_y[idx] = vy;
        written[idx] = 1;
      end else if (kind == pfa_pkg::REQ_LOAD) begin
        org_x[idx] = vx;  org_y[idx] = vy;
        pos_x[idx] = vx;  pos_y[idx] = vy;
        vel_x[idx] = 0;   vel_y[idx] = 0;
        act[idx] = 0;     atime[idx] = 0;
      end else if (kind == pfa_pkg::REQ_STEP) begin
        if (!act[idx] && pos_x[idx] != org_x[idx] && pos_y[idx] != org_y[idx]) begin
          act[idx] = 1;
          atime[idx] = now;
        end
        nx = clamp24(pos_x[idx] + ((vel_x[idx] * dl) >>> 16));
        ny = clamp24(pos_y[idx] + ((vel_y[idx] * dl) >>> 16));
        pos_x[idx] = nx;
        pos_y[idx] = ny;
        vlx = vel_x[idx];
        vly = vel_y[idx];
        if (!skip) begin
          cx = trunc_down(nx * scale_x, 24);
          cy = trunc_down(ny * scale_y, 24);
          if (cx >= 0 && cx < GRID_DIM && cy >= 0 && cy < GRID_DIM) begin
            grid_pos = cy * GRID_DIM + cx;
            vlx = clamp24(vlx + ((gain * force_x[grid_pos] * dl) >>> 24));
            vly = clamp24(vly + ((gain * force_y[grid_pos] * dl) >>> 24));
          end
        end
        damp = rate * dl;
        vel_x[idx] = clamp24(vlx - ((vlx * damp) >>> 32));
        vel_y[idx] = clamp24(vly - ((vly * damp) >>> 32));
        r.id = idx;
        r.pos_x = nx[23:0];
        r.pos_y = ny[23:0];
        r.act = act[idx];
        r.since = act[idx] ? atime[idx] : 32'd0;
        pending_steps.push_back(r);
      end
    endfunction

    task check_result(step_result_t got);
      step_result_t exp_r;
      if (pending_steps.size() == 0) begin
        report($sformatf("unexpected result for particle %0d", got.id));
      end else begin
        exp_r = pending_steps.pop_front();
        steps_checked++;
        if (got.act) active_seen++;
        if (got.id !== exp_r.id)
          report($sformatf("particle_id %0d, want %0d", got.id, exp_r.id));
        if (got.pos_x !== exp_r.pos_x)
          report($sformatf("id %0d new_pos_x %0d, want %0d", exp_r.id, got.pos_x, exp_r.pos_x));
        if (got.pos_y !== exp_r.pos_y)
          report($sformatf("id %0d new_pos_y %0d, want %0d", exp_r.id, got.pos_y, exp_r.pos_y));
        if (got.act !== exp_r.act)
          report($sformatf("id %0d is_active %0b, want %0b", exp_r.id, got.act, exp_r.act));
        if (got.since !== exp_r.since)
          report($sformatf("id %0d active_since %0d, want %0d", exp_r.id, got.since,
                           exp_r.since));
      end
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [1:0] in_req_type = REQ_NONE;
  logic [11:0] in_target_index = '0;
  logic signed [23:0] in_value_x = '0, in_value_y = '0;
  logic [15:0] in_time_step = '0;
  logic [31:0] in_now_time = '0;
  logic in_skip_field = 0;
  logic out_strobe;
  logic [11:0] out_particle_id;
  logic signed [23:0] out_new_pos_x, out_new_pos_y;
  logic out_is_active;
  logic [31:0] out_active_since;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  particle_field_advection_step_top dut (.*);

  advection_scoreboard board = new();
  bit loaded[pfa_pkg::PCOUNT];
  logic [11:0] pool[$];

  initial forever #2 clk = ~clk;

  initial begin
    #2ms;
    $display("particle_field_advection_step_top_tb: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    step_result_t got;
    if (rst_n && out_strobe) begin
      got.id = out_particle_id;
      got.pos_x = out_new_pos_x;
      got.pos_y = out_new_pos_y;
      got.act = out_is_active;
      got.since = out_active_since;
      board.check_result(got);
    end
  end

  task send(logic [1:0] kind, logic [11:0] idx, logic signed [23:0] vx,
            logic signed [23:0] vy, logic [15:0] dt, logic [31:0] now, logic skip);
    logic skip_eff;
    skip_eff = skip;
    if (kind == pfa_pkg::REQ_STEP && !skip && !board.field_ready(idx, dt)) skip_eff = 1;
    start <= 1;
    in_req_type <= kind;
    in_target_index <= idx;
    in_value_x <= vx;
    in_value_y <= vy;
    in_time_step <= dt;
    in_now_time <= now;
    in_skip_field <= skip_eff;
    do @(posedge clk); while (busy);
    board.accept_request(kind, idx, vx, vy, dt, now, skip_eff);
    if (kind == pfa_pkg::REQ_LOAD && !loaded[idx]) begin
      loaded[idx] = 1;
      pool.push_back(idx);
    end
  endtask

  task pause(int cycles);
    start <= 0;
    repeat (cycles) @(posedge clk);
  endtask

  task drain();
    start <= 0;
    do @(posedge clk); while (board.pending_steps.size() != 0);
    repeat (14) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [15:0] val);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0, val};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    board.set_reg(idx, val);
  endtask

  task set_all(logic [15:0] g, logic [15:0] r, logic [15:0] sx, logic [15:0] sy);
    write_reg(pfa_pkg::REG_GAIN, g);
    write_reg(pfa_pkg::REG_RATE, r);
    write_reg(pfa_pkg::REG_SCX, sx);
    write_reg(pfa_pkg::REG_SCY, sy);
  endtask

  function logic signed [23:0] origin_value();
    if ($urandom_range(0, 4) != 0) return 24'($urandom_range(0, 262143));
    return 24'($urandom);
  endfunction

  task random_item();
    int pick;
    logic [11:0] id;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      id = pool[$urandom_range(0, pool.size() - 1)];
      send(pfa_pkg::REQ_STEP, id, 24'($urandom), 24'($urandom), 16'($urandom), $urandom,
           ($urandom_range(0, 5) == 0));
    end else if (pick < 80) begin
      id = ($urandom_range(0, 3) == 0) ? 12'($urandom) : pool[$urandom_range(0, pool.size() - 1)];
      send(pfa_pkg::REQ_LOAD, id, origin_value(), origin_value(), 16'($urandom), $urandom,
           1'($urandom));
    end else if (pick < 95) begin
      send(pfa_pkg::REQ_FIELD, 12'($urandom), 24'($urandom), 24'($urandom), 16'($urandom),
           $urandom, 1'($urandom));
    end else begin
      send(REQ_NONE, 12'($urandom), 24'($urandom), 24'($urandom), 16'($urandom), $urandom,
           1'($urandom));
    end
  endtask

  task random_phase(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        random_item();
        count--;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // A step whose field entry holds no data runs with the field force skipped.
    repeat (512)
      send(pfa_pkg::REQ_FIELD, 12'($urandom), 24'($urandom_range(0, 8191)) - 24'sd4096,
           24'($urandom_range(0, 8191)) - 24'sd4096, '0, '0, 0);
    send(pfa_pkg::REQ_FIELD, 12'd0, 24'sh7FFFFF, 24'sh800000, 16'hFFFF, 32'hFFFFFFFF, 1);
    send(pfa_pkg::REQ_FIELD, 12'd4095, 24'sh800000, 24'sh7FFFFF, 16'h0, 32'h0, 0);
    send(pfa_pkg::REQ_LOAD, 12'd0, 24'sd1000, 24'sd1000, '0, '0, 0);
    send(pfa_pkg::REQ_LOAD, 12'd4095, 24'sh7FFFFF, 24'sh800000, '0, '0, 0);
    send(pfa_pkg::REQ_LOAD, 12'd1, 24'sh800000, 24'sh7FFFFF, '0, '0, 0);
    repeat (40)
      send(pfa_pkg::REQ_LOAD, 12'($urandom), origin_value(), origin_value(), '0, '0, 0);
    send(pfa_pkg::REQ_STEP, 12'd0, '0, '0, 16'hFFFF, 32'd5, 0);
    send(pfa_pkg::REQ_STEP, 12'd0, '0, '0, 16'hFFFF, 32'hFFFFFFFF, 0);
    send(pfa_pkg::REQ_STEP, 12'd0, '0, '0, 16'hFFFF, 32'd7, 1);
    send(pfa_pkg::REQ_STEP, 12'd0, '0, '0, 16'h0, 32'd9, 0);
    send(pfa_pkg::REQ_STEP, 12'd4095, 24'sh7FFFFF, 24'sh800000, 16'hFFFF, 32'h0, 0);
    send(pfa_pkg::REQ_STEP, 12'd1, '0, '0, 16'hFFFF, 32'h1, 0);
    send(REQ_NONE, 12'd5, 24'sd1, 24'sd1, 16'd1, 32'd1, 0);
    drain();

    set_all(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    random_phase(200);
    drain();
    set_all(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    random_phase(200);
    drain();
    set_all(16'($urandom), 16'($urandom), 16'($urandom_range(0, 8192)),
            16'($urandom_range(0, 8192)));
    random_phase(250);
    drain();
    set_all(16'd256, 16'd11796, 16'd4096, 16'd4096);
    random_phase(550);
    drain();

    $display("Checked %0d step results (%0d active) over %0d particles and five settings.",
             board.steps_checked, board.active_seen, pool.size());
    if (board.errors == 0) begin
      $display("particle_field_advection_step_top_tb: done, clean");
    end else begin
      $display("particle_field_advection_step_top_tb: done, errors");
    end
    $finish;
  end
endmodule
